// ----- sv/imh_pkg.sv -----
package imh_pkg;

   localparam int IdW   = 10;
   localparam int DistW = 64;
   localparam int YearW = 32;
   localparam int CntW  = 11;

   typedef enum logic [1:0] {
      FUNC_APPEND   = 2'd0,
      FUNC_DECREASE = 2'd1,
      FUNC_EXTRACT  = 2'd2,
      FUNC_QUERY    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POS,
      S_DEC,
      S_EXT,
      S_EXT2,
      S_UP_RD,
      S_UP_CMP,
      S_UP_FIN,
      S_DN_RD,
      S_DN_L,
      S_DN_R,
      S_DN_FIN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [IdW-1:0]      id;
      logic [DistW-1:0]    distance;
      logic [YearW-1:0]    year;
   } entry_type;

   function automatic logic ranks_before(entry_type a, entry_type b);
      logic sa, sb;
      logic yf;
      sa = a.year[YearW-1];
      sb = b.year[YearW-1];
      if (sa && sb) yf = $signed(a.year) <= $signed(b.year);
      else          yf = $signed(a.year) >= $signed(b.year);
      return (a.distance < b.distance) || ((a.distance == b.distance) && yf);
   endfunction

endpackage

// ----- sv/indexed_min_heap_decrease_key_unit.sv -----
// Path from accept to result register load: full or empty go straight to S_DONE; query and
// absent id pass S_POS; append climbs via S_UP_RD and S_UP_CMP per level, then S_UP_FIN;
// decrease first passes S_POS and S_DEC; extract passes S_EXT, S_EXT2, then per level S_DN_RD,
// S_DN_L, S_DN_R, and finally S_DN_FIN. One item in flight: the next beat is taken after the
// result registers; a held result beat only delays the finish of the following item.
// Reset (synchronous, active high) clears count, control and rsp_tvalid; memories keep no reset.
module indexed_min_heap_decrease_key_unit #(
   parameter int CAPACITY = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // func[1:0], node_id[11:2], new_distance[75:12], new_year[107:76], zero pad
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0], min_id[11:2], min_distance[75:12], min_year[107:76],
   // in_heap[108], heap_empty[109], heap_count[120:110], zero pad
   output logic [127:0]  rsp_tdata
);
   import imh_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;

   entry_type            heap_mem [CAPACITY];
   logic [AW-1:0]        pos_mem  [1 << IdW];

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   func_type             func_ff, func_in;
   entry_type            cur_ff, cur_in;
   entry_type            best_ff, best_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        bidx_ff, bidx_in;
   status_type           st_ff, st_in;
   logic                 inh_ff, inh_in;
   entry_type            min_ff, min_in;
   logic                 swap_ff, swap_in;
   logic [IdW-1:0]       lid_ff, lid_in;
   logic                 ov_ff;
   logic [127:0]         od_ff;

   logic                 h_we;
   logic [AW-1:0]        h_wa, h_ra;
   entry_type            h_wd, h_rd;
   logic                 p_we;
   logic [IdW-1:0]       p_wa, p_ra;
   logic [AW-1:0]        p_wd, p_rd;

   logic [AW-1:0]        parent, left_i, right_i;
   logic [XW-1:0]        left_x, right_x, count_x;
   logic                 take_r;
   entry_type            dn_best;
   logic [AW-1:0]        dn_bidx;
   logic                 fire;
   logic                 load;

   always_ff @(posedge clock) begin
      if (h_we) heap_mem[h_wa] <= h_wd;
      h_rd <= heap_mem[h_ra];
      if (p_we) pos_mem[p_wa] <= p_wd;
      p_rd <= pos_mem[p_ra];
   end

   assign parent  = (idx_ff - AW'(1)) >> 1;
   assign left_x  = {1'b0, idx_ff, 1'b1};
   assign right_x = left_x + XW'(1);
   assign count_x = XW'(count_ff);
   assign left_i  = left_x[AW-1:0];
   assign right_i = right_x[AW-1:0];
   assign take_r  = (right_x < count_x) && ranks_before(h_rd, best_ff);
   assign dn_best = take_r ? h_rd : best_ff;
   assign dn_bidx = take_r ? right_i : bidx_ff;
   assign fire    = req_tvalid && req_tready;
   assign load    = (state_ff == S_DONE) && (!ov_ff || rsp_tready);
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      func_in  = func_ff;
      cur_in   = cur_ff;
      best_in  = best_ff;
      idx_in   = idx_ff;
      bidx_in  = bidx_ff;
      st_in    = st_ff;
      inh_in   = inh_ff;
      min_in   = min_ff;
      swap_in  = swap_ff;
      lid_in   = lid_ff;
      h_we = 1'b0; h_wa = idx_ff; h_wd = cur_ff; h_ra = idx_ff;
      p_we = 1'b0; p_wa = cur_ff.id; p_wd = idx_ff; p_ra = cur_ff.id;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               func_in = func_type'(req_tdata[1:0]);
               cur_in.id       = req_tdata[11:2];
               cur_in.distance = req_tdata[75:12];
               cur_in.year     = req_tdata[107:76];
               st_in   = ST_OK;
               inh_in  = 1'b0;
               min_in  = '0;
               swap_in = 1'b0;
               p_ra    = req_tdata[11:2];
               h_ra    = '0;
               unique case (func_type'(req_tdata[1:0]))
                  FUNC_APPEND: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        st_in = ST_FULL; state_in = S_DONE;
                     end else begin
                        idx_in = count_ff[AW-1:0];
                        count_in = count_ff + CW'(1);
                        state_in = S_UP_RD;
                     end
                  end
                  FUNC_EXTRACT: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY; state_in = S_DONE;
                     end else begin
                        state_in = S_EXT;
                     end
                  end
                  default: state_in = S_POS;
               endcase
            end
         end
         S_POS: begin
            unique case (func_ff)
               FUNC_QUERY: begin
                  inh_in = CW'(p_rd) < count_ff;
                  state_in = S_DONE;
               end
               default: begin
                  if (CW'(p_rd) >= count_ff) begin
                     st_in = ST_ABSENT; state_in = S_DONE;
                  end else begin
                     idx_in = p_rd;
                     h_ra = p_rd;
                     state_in = S_DEC;
                  end
               end
            endcase
         end
         S_DEC: begin
            cur_in.id = h_rd.id;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            if (idx_ff == '0) state_in = S_UP_FIN;
            else begin
               h_ra = parent;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (ranks_before(cur_ff, h_rd)) begin
               h_we = 1'b1; h_wd = h_rd;
               p_we = 1'b1; p_wa = h_rd.id; p_wd = idx_ff;
               swap_in = 1'b1;
               lid_in = h_rd.id;
               idx_in = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_UP_FIN;
            end
         end
         S_UP_FIN: begin
            h_we = 1'b1;
            // last swap partner with the same id already holds the final position
            p_we = (swap_ff || func_ff == FUNC_APPEND) && !(swap_ff && lid_ff == cur_ff.id);
            state_in = S_DONE;
         end
         S_EXT: begin
            min_in = h_rd;
            h_ra = AW'(count_ff - CW'(1));
            p_we = 1'b1; p_wa = h_rd.id; p_wd = AW'(count_ff - CW'(1));
            state_in = S_EXT2;
         end
         S_EXT2: begin
            cur_in = h_rd;
            count_in = count_ff - CW'(1);
            idx_in = '0;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            best_in = cur_ff; bidx_in = idx_ff;
            if (left_x >= count_x) state_in = S_DN_FIN;
            else begin
               h_ra = left_i;
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            if (ranks_before(h_rd, best_ff)) begin
               best_in = h_rd; bidx_in = left_i;
            end
            h_ra = right_i;
            state_in = S_DN_R;
         end
         S_DN_R: begin
            if (dn_bidx == idx_ff) state_in = S_DN_FIN;
            else begin
               h_we = 1'b1; h_wd = dn_best;
               p_we = 1'b1; p_wa = dn_best.id; p_wd = idx_ff;
               idx_in = dn_bidx;
               state_in = S_DN_RD;
            end
         end
         S_DN_FIN: begin
            h_we = 1'b1;
            p_we = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
      func_ff <= func_in;
      cur_ff  <= cur_in;
      best_ff <= best_in;
      idx_ff  <= idx_in;
      bidx_ff <= bidx_in;
      st_ff   <= st_in;
      inh_ff  <= inh_in;
      min_ff  <= min_in;
      swap_ff <= swap_in;
      lid_ff  <= lid_in;
      if (load) begin
         od_ff <= {7'd0, CntW'(count_ff), (count_ff == '0), inh_ff,
                   min_ff.year, min_ff.distance, min_ff.id, st_ff};
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count overflow");
   a_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("accept while busy");
   a_ext: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXT2) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("extract count");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped");
endmodule
